// ===== hw/rtl/jet_pkg.sv =====
// Shared constants and controller/datapath interface types for the Julia escape-time block.
package jet_pkg;

  // Field and port widths fixed by the interface.
  localparam int PIXEL_W    = 12;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RADIUS_W   = 7;

  // The configured c_real, c_imag and inv_scale values are given with this many fraction bits.
  localparam int Q28_FRAC = 28;

  // Defaults for the top-level parameters.
  localparam int FRAC_BITS_DEF   = 28;
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_C_REAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd4;

  // Configuration reset values.
  localparam logic [CFG_DATA_W-1:0] RST_INV_SCALE = 32'd1048576;
  localparam logic [RADIUS_W-1:0]   RST_RADIUS_SQ = 7'd4;
  localparam logic [ITER_W-1:0]     RST_MAX_ITER  = 16'd255;

  // Operand selection for the shared multiplier.
  localparam logic [2:0] MUL_PX = 3'd0;
  localparam logic [2:0] MUL_PY = 3'd1;
  localparam logic [2:0] MUL_RR = 3'd2;
  localparam logic [2:0] MUL_II = 3'd3;
  localparam logic [2:0] MUL_RI = 3'd4;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic       load_px;
    logic       load_zr0;
    logic       load_zi0;
    logic       load_rr;
    logic       load_ii;
    logic       clr_count;
    logic       update;
  } jet_cmd_t;

  typedef struct packed {
    logic count_done;
    logic escape;
  } jet_status_t;

endpackage

// ===== hw/rtl/jet_dp.sv =====
// Datapath: start point scaling, shared multiplier, escape test and iteration counter.
module jet_dp import jet_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  jet_cmd_t                   cmd,
  output jet_status_t                status,
  input  logic signed [PIXEL_W-1:0]  pixel_x,
  input  logic signed [PIXEL_W-1:0]  pixel_y,
  input  logic signed [CFG_DATA_W-1:0] c_real,
  input  logic signed [CFG_DATA_W-1:0] c_imag,
  input  logic [CFG_DATA_W-1:0]      inv_scale,
  input  logic [RADIUS_W-1:0]        escape_radius_sq,
  input  logic [ITER_W-1:0]          max_iterations,
  output logic [ITER_W-1:0]          iteration_count
);

  localparam int W   = FRAC_BITS + 4;
  localparam int MW  = (W > CFG_DATA_W + 1) ? W : CFG_DATA_W + 1;
  localparam int UP  = (FRAC_BITS >= Q28_FRAC) ? FRAC_BITS - Q28_FRAC : 0;
  localparam int DN  = (FRAC_BITS < Q28_FRAC) ? Q28_FRAC - FRAC_BITS : 0;
  localparam int XW  = 2 * MW + UP;
  localparam int DW  = FRAC_BITS + 10;
  localparam int LW  = (COUNT_WIDTH > ITER_W) ? COUNT_WIDTH : ITER_W;

  localparam logic signed [XW-1:0] QHI = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [XW-1:0] QLO = ~QHI;

  function automatic logic signed [W-1:0] sat_q(input logic signed [XW-1:0] v);
    logic signed [W-1:0] r;
    if (v > QHI) begin
      r = QHI[W-1:0];
    end else if (v < QLO) begin
      r = QLO[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // Floor conversion from 28 fraction bits to FRAC_BITS fraction bits.
  function automatic logic signed [XW-1:0] from_q28(input logic signed [XW-1:0] v);
    return (v <<< UP) >>> DN;
  endfunction

  logic signed [PIXEL_W-1:0] px;
  logic signed [PIXEL_W-1:0] py;
  logic signed [W-1:0]       zr;
  logic signed [W-1:0]       zi;
  logic signed [DW-1:0]      rr;
  logic signed [DW-1:0]      ii;
  logic signed [2*MW-1:0]    prod;
  logic [COUNT_WIDTH-1:0]    count;

  logic signed [MW-1:0]      mul_a;
  logic signed [MW-1:0]      mul_b;
  logic signed [W-1:0]       cr;
  logic signed [W-1:0]       ci;
  logic signed [XW-1:0]      prod_q28;
  logic signed [XW-1:0]      prod_floor;
  logic signed [DW-1:0]      ii_now;
  logic signed [DW-1:0]      bound;
  logic signed [XW-1:0]      zr_sum;
  logic signed [XW-1:0]      zi_sum;
  logic [LW-1:0]             max_ext;
  logic [LW-1:0]             cap_ext;
  logic [COUNT_WIDTH-1:0]    limit;

  assign cr = sat_q(from_q28(XW'(c_real)));
  assign ci = sat_q(from_q28(XW'(c_imag)));

  always_comb begin
    mul_a = MW'(zr);
    mul_b = MW'(zr);
    case (cmd.mul_sel)
      MUL_PX: begin
        mul_a = MW'(px);
        mul_b = MW'({1'b0, inv_scale});
      end
      MUL_PY: begin
        mul_a = MW'(py);
        mul_b = MW'({1'b0, inv_scale});
      end
      MUL_RR: begin
        mul_a = MW'(zr);
        mul_b = MW'(zr);
      end
      MUL_II: begin
        mul_a = MW'(zi);
        mul_b = MW'(zi);
      end
      MUL_RI: begin
        mul_a = MW'(zr);
        mul_b = MW'(zi);
      end
      default: begin
        mul_a = MW'(zr);
        mul_b = MW'(zr);
      end
    endcase
  end

  // The arithmetic shift of the exact product gives the floor of each quotient.
  assign prod_q28   = XW'(prod);
  assign prod_floor = XW'(prod >>> FRAC_BITS);
  assign ii_now     = DW'(prod >>> FRAC_BITS);
  assign bound      = DW'({escape_radius_sq, {FRAC_BITS{1'b0}}});
  assign zr_sum     = XW'(rr) - XW'(ii) + XW'(cr);
  assign zi_sum     = (prod_floor <<< 1) + XW'(ci);

  assign max_ext = LW'(max_iterations);
  assign cap_ext = LW'({COUNT_WIDTH{1'b1}});
  assign limit   = (max_ext > cap_ext) ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(max_ext);

  assign status.count_done = (count >= limit);
  assign status.escape     = ((rr + ii_now) >= bound);
  assign iteration_count   = ITER_W'(count);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load_px) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.load_zr0) begin
      zr <= sat_q(from_q28(prod_q28));
    end
    if (cmd.load_zi0) begin
      zi <= sat_q(from_q28(prod_q28));
    end
    if (cmd.load_rr) begin
      rr <= DW'(prod >>> FRAC_BITS);
    end
    if (cmd.load_ii) begin
      ii <= ii_now;
    end
    if (cmd.update) begin
      zr <= sat_q(zr_sum);
      zi <= sat_q(zi_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clr_count) begin
      count <= '0;
    end else if (cmd.update) begin
      count <= count + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/jet_ctrl.sv =====
// Controller: sequences start-point scaling, the iteration steps and the result hand-off.
module jet_ctrl import jet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        out_free,
  output logic        out_load,
  input  jet_status_t status,
  output jet_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SX   = 4'd1;
  localparam logic [3:0] S_SY   = 4'd2;
  localparam logic [3:0] S_LD   = 4'd3;
  localparam logic [3:0] S_MRR  = 4'd4;
  localparam logic [3:0] S_MII  = 4'd5;
  localparam logic [3:0] S_MRI  = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_RR;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_px = 1'b1;
          state_next  = S_SX;
        end
      end
      S_SX: begin
        cmd.mul_sel = MUL_PX;
        state_next  = S_SY;
      end
      S_SY: begin
        cmd.mul_sel  = MUL_PY;
        cmd.load_zr0 = 1'b1;
        state_next   = S_LD;
      end
      S_LD: begin
        cmd.load_zi0  = 1'b1;
        cmd.clr_count = 1'b1;
        state_next    = S_MRR;
      end
      S_MRR: begin
        cmd.mul_sel = MUL_RR;
        state_next  = status.count_done ? S_DONE : S_MII;
      end
      S_MII: begin
        cmd.mul_sel = MUL_II;
        cmd.load_rr = 1'b1;
        state_next  = S_MRI;
      end
      S_MRI: begin
        // The product register holds zi*zi here, so the radius test sees both squares.
        cmd.mul_sel = MUL_RI;
        cmd.load_ii = 1'b1;
        state_next  = status.escape ? S_DONE : S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_MRR;
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/julia_escape_time.sv =====
// Julia-set escape-time counter: top level with configuration registers and output register.
//
// One transaction on the s_axis channel carries a pixel offset pair; the block
// scales it by inv_scale into a start point z and repeats z = z*z + c until
// |z|^2 reaches the squared radius or the count reaches max_iterations. One
// transaction on the m_axis channel returns the count.
// Configuration writes on the cfg channel are always accepted (cfg_ready is
// tied high) and must only happen while no pixel is in flight.
// Each iteration runs through S_MRR, S_MII and S_MRI on the single shared
// multiplier, which computes zr*zr, zi*zi and zr*zi in turn, and then S_UPD,
// which updates z. A pixel passes from acceptance through S_SX, S_SY and S_LD
// into the iteration states and then to S_DONE, where its result is loaded
// into the output register once that is free. The next pixel can be accepted
// in the cycle after the load. The limit is tested in S_MRR, the escape in S_MRI.
// One pixel is worked on at a time; a new pixel is accepted as soon as the
// previous result sits in the output register, even while that result waits.
// If the receiver stalls with a result still held, a finished pixel waits in
// the datapath until the output register frees up.
// Reset clears the controller and the output valid and restores all
// configuration registers to their defaults.
module julia_escape_time import jet_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [2*PIXEL_W-1:0]    s_axis_tdata,  // pixel_x, pixel_y
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [ITER_W-1:0]       m_axis_tdata,  // iteration_count
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic signed [CFG_DATA_W-1:0] c_real;
  logic signed [CFG_DATA_W-1:0] c_imag;
  logic [CFG_DATA_W-1:0]        inv_scale;
  logic [RADIUS_W-1:0]          escape_radius_sq;
  logic [ITER_W-1:0]            max_iterations;

  jet_cmd_t          cmd;
  jet_status_t       status;
  logic              out_free;
  logic              out_load;
  logic [ITER_W-1:0] iteration_count;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real           <= '0;
      c_imag           <= '0;
      inv_scale        <= RST_INV_SCALE;
      escape_radius_sq <= RST_RADIUS_SQ;
      max_iterations   <= RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_C_REAL:    c_real           <= cfg_data;
        CFG_C_IMAG:    c_imag           <= cfg_data;
        CFG_INV_SCALE: inv_scale        <= cfg_data;
        CFG_RADIUS_SQ: escape_radius_sq <= cfg_data[RADIUS_W-1:0];
        CFG_MAX_ITER:  max_iterations   <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  jet_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .pixel_x          (s_axis_tdata[PIXEL_W-1:0]),
    .pixel_y          (s_axis_tdata[2*PIXEL_W-1:PIXEL_W]),
    .c_real           (c_real),
    .c_imag           (c_imag),
    .inv_scale        (inv_scale),
    .escape_radius_sq (escape_radius_sq),
    .max_iterations   (max_iterations),
    .iteration_count  (iteration_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= iteration_count;
    end
  end

  // A result may only be loaded when the held one has gone or is leaving.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over a pending result");

  // One pixel at a time: an accepted pixel closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a pixel is in flight");

  // The count never exceeds the configured limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= max_iterations))
    else $error("iteration count beyond the limit");

endmodule
